// ===== hdl/csf_pkg.sv =====
`default_nettype none

package csf_pkg;

  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLS    = 64;
  localparam int CELL_COUNT  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W      = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int RCNT_W      = $clog2(MAX_ROWS + 1);
  localparam int CCNT_W      = $clog2(MAX_COLS + 1);
  localparam int DELTA_W     = 11;
  localparam int QUEUE_DEPTH = 2;
  localparam int PADDR_W     = 3;

  localparam logic [7:0] CELL_BLANK = 8'd46;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic [2:0] OP_RECT     = 3'd0;
  localparam logic [2:0] OP_UP_TRI   = 3'd1;
  localparam logic [2:0] OP_DOWN_TRI = 3'd2;
  localparam logic [2:0] OP_DIAMOND  = 3'd3;
  localparam logic [2:0] OP_CLEAR    = 3'd4;
  localparam logic [2:0] OP_READ     = 3'd5;

  typedef enum logic [1:0] {
    KIND_NOP,
    KIND_FILL,
    KIND_CLEAR,
    KIND_READ
  } kind_t;

  typedef enum logic [1:0] {
    SHAPE_RECT,
    SHAPE_UP,
    SHAPE_DOWN,
    SHAPE_DIAMOND
  } shape_t;

  typedef struct packed {
    logic [RCNT_W-1:0] rows;
    logic [CCNT_W-1:0] cols;
  } dims_t;

  typedef struct packed {
    kind_t              kind;
    shape_t             shape;
    logic signed [7:0]  px;
    logic signed [7:0]  py;
    logic [6:0]         w;
    logic [6:0]         h;
    logic [7:0]         brush;
    logic [ADDR_W-1:0]  raddr;
    logic               rhit;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/clipped_shape_fill_framebuffer.sv =====
// A read cell transaction passes through S_READ to S_POST, a no-op goes straight to S_POST,
// a fill steps through rows*cols cells, one cell per cycle through the write port, and a clear
// through all 4096 cells. The back end takes no new transaction until its result is registered;
// a two-entry queue lets the input accept up to two further transactions meanwhile.
// Reset: synchronous. Size registers return to 64 and a clearing pass writes '.' to every cell,
// with in_stall held high until it ends.
`default_nettype none

module clipped_shape_fill_framebuffer import csf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         opcode,
  input  logic signed [7:0]  pos_x,
  input  logic signed [7:0]  pos_y,
  input  logic [6:0]         extent_w,
  input  logic [6:0]         extent_h,
  input  logic [7:0]         brush,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         cell_value,
  output logic               read_valid
);

  logic [6:0] canvas_rows;
  logic [6:0] canvas_cols;
  dims_t      dims;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  logic       push;
  logic       init_busy;
  cmd_t       cmd;
  cmd_t       q_head;

  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      REG_ROWS: prdata = {25'd0, canvas_rows};
      REG_COLS: prdata = {25'd0, canvas_cols};
      default:  prdata = 32'd0;
    endcase
    dims.rows = (int'(canvas_rows) > MAX_ROWS) ? RCNT_W'(MAX_ROWS) : RCNT_W'(canvas_rows);
    dims.cols = (int'(canvas_cols) > MAX_COLS) ? CCNT_W'(MAX_COLS) : CCNT_W'(canvas_cols);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_rows <= 7'd64;
      canvas_cols <= 7'd64;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_ROWS: canvas_rows <= pwdata[6:0];
        REG_COLS: canvas_cols <= pwdata[6:0];
        default:  canvas_rows <= canvas_rows;
      endcase
    end
  end

  csf_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .extent_w  (extent_w),
    .extent_h  (extent_h),
    .brush     (brush),
    .dims      (dims),
    .q_full    (q_full),
    .init_busy (init_busy),
    .push      (push),
    .cmd       (cmd)
  );

  csf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (cmd),
    .pop       (q_pop),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head)
  );

  csf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .dims       (dims),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .init_busy  (init_busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cell_value (cell_value),
    .read_valid (read_valid)
  );

endmodule

`default_nettype wire

// ===== hdl/csf_front.sv =====
`default_nettype none

module csf_front import csf_pkg::*; (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        opcode,
  input  logic signed [7:0] pos_x,
  input  logic signed [7:0] pos_y,
  input  logic [6:0]        extent_w,
  input  logic [6:0]        extent_h,
  input  logic [7:0]        brush,
  input  dims_t             dims,
  input  logic              q_full,
  input  logic              init_busy,
  output logic              push,
  output cmd_t              cmd
);

  localparam int CALC_W = ADDR_W + 9;

  logic              dims_empty;
  logic              x_in;
  logic              y_in;
  logic [CALC_W-1:0] addr_full;

  assign in_stall = q_full || init_busy;
  assign push     = in_valid && !in_stall;

  always_comb begin
    dims_empty = (dims.rows == '0) || (dims.cols == '0);
    x_in       = (pos_x >= 0) && (int'(pos_x) < int'(dims.cols));
    y_in       = (pos_y >= 0) && (int'(pos_y) < int'(dims.rows));
    addr_full  = CALC_W'($unsigned(pos_y)) * CALC_W'(MAX_COLS) + CALC_W'($unsigned(pos_x));

    cmd.px    = pos_x;
    cmd.py    = pos_y;
    cmd.w     = extent_w;
    cmd.h     = extent_h;
    cmd.brush = brush;
    cmd.raddr = addr_full[ADDR_W-1:0];
    cmd.rhit  = x_in && y_in;
    cmd.shape = SHAPE_RECT;
    cmd.kind  = KIND_NOP;

    unique case (opcode) inside
      OP_RECT: begin
        cmd.shape = SHAPE_RECT;
        cmd.kind  = (extent_w == '0 || extent_h == '0 || dims_empty) ? KIND_NOP : KIND_FILL;
      end
      OP_UP_TRI, OP_DOWN_TRI: begin
        cmd.shape = (opcode == OP_UP_TRI) ? SHAPE_UP : SHAPE_DOWN;
        cmd.kind  = (extent_h == '0 || dims_empty) ? KIND_NOP : KIND_FILL;
      end
      OP_DIAMOND: begin
        cmd.shape = SHAPE_DIAMOND;
        cmd.kind  = dims_empty ? KIND_NOP : KIND_FILL;
      end
      OP_CLEAR: begin
        cmd.kind = KIND_CLEAR;
      end
      OP_READ: begin
        cmd.kind = KIND_READ;
      end
      default: begin
        cmd.kind = KIND_NOP;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/csf_queue.sv =====
`default_nettype none

module csf_queue import csf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output logic full,
  output logic valid,
  output cmd_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/csf_back.sv =====
`default_nettype none

module csf_back import csf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  dims_t      dims,
  input  logic       q_valid,
  input  cmd_t       q_head,
  output logic       q_pop,
  output logic       init_busy,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] cell_value,
  output logic       read_valid
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_FILL,
    S_CLEAR,
    S_READ,
    S_POST
  } state_t;

  state_t                    state;
  cmd_t                      cur;
  logic [7:0]                mem [CELL_COUNT];
  logic [7:0]                rdata;
  logic [ADDR_W-1:0]         addr;
  logic [ADDR_W-1:0]         row_base;
  logic [RCNT_W-1:0]         row;
  logic [CCNT_W-1:0]         col;
  logic signed [DELTA_W-1:0] dx;
  logic signed [DELTA_W-1:0] dy;
  logic signed [DELTA_W-1:0] dx_start;
  logic signed [DELTA_W-1:0] dy_start;
  logic signed [DELTA_W-1:0] dx_row;
  logic signed [DELTA_W-1:0] hs;
  logic signed [DELTA_W-1:0] ws;
  logic signed [DELTA_W-1:0] adx;
  logic signed [DELTA_W-1:0] ndy;
  logic signed [DELTA_W-1:0] dyh;
  logic signed [DELTA_W-1:0] adyh;
  logic [7:0]                res_value;
  logic                      res_valid;
  logic                      covered;
  logic                      we;
  logic                      rd_en;
  logic                      row_end;
  logic                      last_row;
  logic                      last_addr;
  logic [7:0]                wdata;

  always_comb begin
    hs   = $signed({{(DELTA_W-7){1'b0}}, cur.h});
    ws   = $signed({{(DELTA_W-7){1'b0}}, cur.w});
    adx  = dx[DELTA_W-1] ? -dx : dx;
    ndy  = -dy;
    dyh  = dy - hs;
    adyh = dyh[DELTA_W-1] ? -dyh : dyh;

    unique case (cur.shape)
      SHAPE_RECT:    covered = (dx >= 0) && (dx < ws) && (dy >= 0) && (dy < hs);
      SHAPE_UP:      covered = (dy >= 0) && (dy < hs) && (adx <= dy);
      SHAPE_DOWN:    covered = (ndy >= 0) && (ndy < hs) && (adx <= ndy);
      SHAPE_DIAMOND: covered = (dy >= 0) && (dy <= (hs <<< 1)) && (adx <= hs - adyh);
      default:       covered = 1'b0;
    endcase
  end

  assign dx_start  = -DELTA_W'(q_head.px);
  assign dy_start  = -DELTA_W'(q_head.py);
  assign dx_row    = -DELTA_W'(cur.px);
  assign row_end   = ((col + 1'b1) == dims.cols);
  assign last_row  = ((row + 1'b1) == dims.rows);
  assign last_addr = (addr == ADDR_W'(CELL_COUNT - 1));
  assign init_busy = (state == S_INIT);
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign rd_en     = q_pop && (q_head.kind == KIND_READ);
  assign we        = (state == S_INIT) || (state == S_CLEAR) || ((state == S_FILL) && covered);
  assign wdata     = (state == S_FILL) ? cur.brush : CELL_BLANK;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[q_head.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      addr      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_POST)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          if (last_addr) begin
            state <= S_IDLE;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_head;
            unique case (q_head.kind)
              KIND_FILL: begin
                row      <= '0;
                col      <= '0;
                addr     <= '0;
                row_base <= '0;
                dx       <= dx_start;
                dy       <= dy_start;
                state    <= S_FILL;
              end
              KIND_CLEAR: begin
                addr  <= '0;
                state <= S_CLEAR;
              end
              KIND_READ: begin
                state <= S_READ;
              end
              default: begin
                res_value <= 8'd0;
                res_valid <= 1'b0;
                state     <= S_POST;
              end
            endcase
          end
        end
        S_FILL: begin
          if (row_end) begin
            if (last_row) begin
              res_value <= 8'd0;
              res_valid <= 1'b0;
              state     <= S_POST;
            end else begin
              row      <= row + 1'b1;
              col      <= '0;
              row_base <= row_base + ADDR_W'(MAX_COLS);
              addr     <= row_base + ADDR_W'(MAX_COLS);
              dx       <= dx_row;
              dy       <= dy + DELTA_W'(1);
            end
          end else begin
            col  <= col + 1'b1;
            addr <= addr + 1'b1;
            dx   <= dx + DELTA_W'(1);
          end
        end
        S_CLEAR: begin
          if (last_addr) begin
            res_value <= 8'd0;
            res_valid <= 1'b0;
            state     <= S_POST;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        S_READ: begin
          res_value <= cur.rhit ? rdata : 8'd0;
          res_valid <= cur.rhit;
          state     <= S_POST;
        end
        S_POST: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            cell_value <= res_value;
            read_valid <= res_valid;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/csf_checker.sv =====
`default_nettype none

module csf_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] cell_value,
  input logic       read_valid
);

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cell_value) && $stable(read_valid))
    else $error("result changed while stalled");

  // A result that is not a hit carries a zero cell value.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !read_valid |-> cell_value == 8'd0)
    else $error("nonzero cell value on a miss");

  // The clearing pass after reset blocks input transactions.
  a_init_stall: assert property (@(posedge clk) $past(rst) |-> in_stall)
    else $error("input accepted during clearing pass");

  // Reset empties the result register.
  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind clipped_shape_fill_framebuffer csf_checker u_csf_checker (.*);

`default_nettype wire
